// File: src/reference_slot_allocator_defines.svh
// Assertion macros for the reference slot allocator.
// Included by modules that carry concurrent checks; needs clk and rst in scope.
`ifndef REFERENCE_SLOT_ALLOCATOR_DEFINES_SVH
`define REFERENCE_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RSA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rsa_pkg.sv
// Package for the reference slot allocator: sizes, codes, item types and
// the find-first-set helper. No dependencies.
`default_nettype none

package rsa_pkg;

  localparam int SLOTS    = 64;
  localparam int PTR_BITS = 32;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCAN   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_BUSY  = 2'd2,
    STAT_NONE_BUSY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [PTR_BITS-1:0] ptr;
    logic [5:0]          idx;
    logic [1:0]          kind;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [31:0] ptr;
    logic [1:0]  kind;
    status_t     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       any;
    logic [5:0] idx;
  } ffs_t;

  // Lowest set bit of a 64-bit vector, as eight groups of eight.
  function automatic ffs_t ffs64(input logic [63:0] v);
    logic [7:0] grp_any;
    logic [2:0] grp_pos [8];
    logic [2:0] g;
    ffs_t       r;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |v[i*8 +: 8];
      grp_pos[i] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (v[i*8 + j]) grp_pos[i] = 3'(j);
      end
    end
    g = '0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) g = 3'(i);
    end
    r.any = |grp_any;
    r.idx = {g, grp_pos[g]};
    return r;
  endfunction

  function automatic logic [PTR_BITS-1:0] ptr_to_store(input logic [31:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[PTR_BITS-1:0];
  endfunction

  function automatic logic [31:0] ptr_to_out(input logic [PTR_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

// File: src/rsa_if.sv
// Valid/ready channel interfaces for request and result items.
// No dependencies.
`default_nettype none

interface rsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] object_pointer;
  logic [5:0]  slot_index;
  logic [1:0]  ref_kind;

  modport source (output valid, op, object_pointer, slot_index, ref_kind, input ready);
  modport sink   (input valid, op, object_pointer, slot_index, ref_kind, output ready);
endinterface

interface rsa_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  slot;
  logic [31:0] pointer_out;
  logic [1:0]  kind_out;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, slot, pointer_out, kind_out, status, last, input ready);
  modport sink   (input valid, slot, pointer_out, kind_out, status, last, output ready);
endinterface

`default_nettype wire

// File: src/reference_slot_allocator.sv
// Path: an add goes from the queue into the result register; a remove of a busy slot and the first
// scan result also take a registered pointer store read (queue stage, back end, registered read).
// Flow: the back end takes a new item only after the result of the last one is accepted, and a
// scan reads the pointer store once per busy slot reported (one read port, one read per slot).
// Reset: all slots free, queue empty; the pointer store is not cleared.
// Top level: request item front end, command queue, allocator back end.
`default_nettype none

module reference_slot_allocator (
  input  logic       clk,
  input  logic       rst,
  rsa_in_if.sink     req,
  rsa_out_if.source  rsp
);
  import rsa_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  rsa_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rsa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop_ready),
    .cmd     (pop_data),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: src/rsa_front.sv
// Front end: takes request items, drops unused op codes, and packs the
// rest into commands for the queue. Uses rsa_pkg and rsa_in_if.
`default_nettype none

module rsa_front (
  rsa_in_if.sink         req,
  output logic           push_valid,
  input  logic           push_ready,
  output rsa_pkg::cmd_t  push_data
);
  import rsa_pkg::*;

  logic known_op;

  assign known_op = (req.op == OP_ADD) || (req.op == OP_REMOVE) || (req.op == OP_SCAN);

  assign req.ready       = push_ready;
  assign push_valid      = req.valid && known_op;
  assign push_data.op    = op_t'(req.op);
  assign push_data.ptr   = ptr_to_store(req.object_pointer);
  assign push_data.idx   = req.slot_index;
  assign push_data.kind  = req.ref_kind;

endmodule

`default_nettype wire

// File: src/rsa_queue.sv
// Short command queue between front and back end.
// Uses rsa_pkg for the command type and depth.
`default_nettype none

module rsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rsa_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rsa_pkg::cmd_t pop_data
);
  import rsa_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// File: src/rsa_back.sv
// Back end: free bitmap, pointer store, find-first-set allocation and the
// scan walk, with a registered result. Uses rsa_pkg, rsa_out_if and the macros.
`include "reference_slot_allocator_defines.svh"
`default_nettype none

module rsa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  rsa_pkg::cmd_t cmd,
  rsa_out_if.source     rsp
);
  import rsa_pkg::*;

  state_t              state, state_next;
  logic [SLOTS-1:0]    free_map, free_map_next;
  logic [SLOTS-1:0]    busy;
  logic                scan, scan_next;
  res_t                res, res_next;

  logic [PTR_BITS-1:0] mem [SLOTS];
  logic [PTR_BITS-1:0] rdata;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [SLOT_W-1:0]   mem_raddr;
  logic [PTR_BITS-1:0] mem_wdata;

  logic [63:0]         busy_ext;
  logic [63:0]         above_ext;
  ffs_t                free_ffs, busy_ffs, above_ffs;
  logic                rm_busy;

  assign busy     = ~free_map;
  assign busy_ext = 64'(busy);

  // busy slots strictly above the slot currently held in the result
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      above_ext[i] = busy_ext[i] & (7'(i) > {1'b0, res.slot});
    end
  end

  assign free_ffs  = ffs64(64'(free_map));
  assign busy_ffs  = ffs64(busy_ext);
  assign above_ffs = ffs64(above_ext);
  assign rm_busy   = (32'(cmd.idx) < SLOTS) && !free_map[cmd.idx[SLOT_W-1:0]];

  assign rsp.valid       = (state == ST_SEND);
  assign rsp.slot        = res.slot;
  assign rsp.pointer_out = res.ptr;
  assign rsp.kind_out    = res.kind;
  assign rsp.status      = res.status;
  assign rsp.last        = res.last;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      free_map <= '1;
      scan     <= 1'b0;
    end else begin
      state    <= state_next;
      free_map <= free_map_next;
      scan     <= scan_next;
    end
    res <= res_next;
  end

  always_comb begin
    state_next    = state;
    free_map_next = free_map;
    scan_next     = scan;
    res_next      = res;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = free_ffs.idx[SLOT_W-1:0];
    mem_wdata     = cmd.ptr;
    mem_raddr     = cmd.idx[SLOT_W-1:0];
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          scan_next     = 1'b0;
          res_next.kind = cmd.kind;
          res_next.last = 1'b1;
          res_next.ptr  = '0;
          case (cmd.op)
            OP_ADD: begin
              state_next = ST_SEND;
              if (free_ffs.any) begin
                free_map_next[free_ffs.idx[SLOT_W-1:0]] = 1'b0;
                mem_we          = 1'b1;
                res_next.slot   = free_ffs.idx;
                res_next.ptr    = ptr_to_out(cmd.ptr);
                res_next.status = STAT_OK;
              end else begin
                res_next.slot   = '0;
                res_next.status = STAT_FULL;
              end
            end
            OP_REMOVE: begin
              res_next.slot = cmd.idx;
              if (rm_busy) begin
                free_map_next[cmd.idx[SLOT_W-1:0]] = 1'b1;
                res_next.status = STAT_OK;
                state_next      = ST_READ;
              end else begin
                res_next.status = STAT_NOT_BUSY;
                state_next      = ST_SEND;
              end
            end
            OP_SCAN: begin
              if (busy_ffs.any) begin
                scan_next       = 1'b1;
                res_next.slot   = busy_ffs.idx;
                res_next.status = STAT_OK;
                mem_raddr       = busy_ffs.idx[SLOT_W-1:0];
                state_next      = ST_READ;
              end else begin
                res_next.slot   = '0;
                res_next.status = STAT_NONE_BUSY;
                state_next      = ST_SEND;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        res_next.ptr  = ptr_to_out(rdata);
        res_next.last = scan ? !above_ffs.any : 1'b1;
        state_next    = ST_SEND;
      end
      ST_SEND: begin
        if (rsp.ready) begin
          if (scan && !res.last) begin
            res_next.slot = above_ffs.idx;
            mem_raddr     = above_ffs.idx[SLOT_W-1:0];
            state_next    = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RSA_ASSERT_NOW(a_full_means_empty_map, state == ST_SEND && res.status == STAT_FULL, free_map == '0, "full status with a free slot")
  `RSA_ASSERT_NOW(a_single_result_last, state == ST_SEND && !scan, res.last, "single result not marked last")
  `RSA_ASSERT_NEXT(a_scan_ascending, state == ST_SEND && rsp.ready && scan && !res.last, state == ST_READ && res.slot > $past(res.slot), "scan slot order broken")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for reference_slot_allocator: a directed table, then
// fill/drain random traffic checked against an in-bench model of the slot table.
// Depends on rsa_pkg (src/rsa_pkg.sv) and the channel interfaces (src/rsa_if.sv).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PER_PHASE = 134;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ptr;
    logic [5:0]  idx;
    logic [1:0]  kind;
    logic        typed;
    logic [5:0]  t_slot;
    logic [31:0] t_ptr;
    status_t     t_status;
  } req_row_t;

  logic clk;
  logic rst;

  rsa_in_if  req_ch ();
  rsa_out_if rsp_ch ();

  reference_slot_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // model of the slot table
  logic [63:0] free_slots;
  logic [31:0] held_ptr [64];

  res_t pending_results[$];
  int   error_count;
  int   cycle_count;
  int   requests_done;
  int   results_seen;
  int   longest_scan;
  int   status_tally [4];
  int   src_idle_pct;
  int   rx_stall_pct;
  bit   filling;
  int   full_hits;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      status_tally[rsp_ch.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: slot %0d status %0d",
               rsp_ch.slot, rsp_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
        check_field("pointer_out", want.ptr, rsp_ch.pointer_out);
        check_field("kind_out", 32'(want.kind), 32'(rsp_ch.kind_out));
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("last", 32'(want.last), 32'(rsp_ch.last));
      end
    end
  end

  function automatic void predict_slot_results(input req_row_t r, ref res_t due[$]);
    res_t e;
    int   top;
    int   n;
    e.slot = '0;
    e.ptr = '0;
    e.kind = r.kind;
    e.status = STAT_OK;
    e.last = 1'b1;
    top = 0;
    n = 0;
    case (r.op)
      OP_ADD: begin
        if (free_slots == '0) begin
          e.status = STAT_FULL;
        end else begin
          for (int i = 63; i >= 0; i--) if (free_slots[i]) e.slot = 6'(i);
          held_ptr[e.slot] = r.ptr;
          free_slots[e.slot] = 1'b0;
          e.ptr = r.ptr;
        end
        due = {due, e};
      end
      OP_REMOVE: begin
        e.slot = r.idx;
        if (free_slots[r.idx]) begin
          e.status = STAT_NOT_BUSY;
        end else begin
          e.ptr = held_ptr[r.idx];
          free_slots[r.idx] = 1'b1;
        end
        due = {due, e};
      end
      OP_SCAN: begin
        if (&free_slots) begin
          e.status = STAT_NONE_BUSY;
          due = {due, e};
        end else begin
          for (int i = 0; i < 64; i++) if (!free_slots[i]) top = i;
          for (int i = 0; i < 64; i++) begin
            if (!free_slots[i]) begin
              e.slot = 6'(i);
              e.ptr = held_ptr[i];
              e.last = (i == top);
              due = {due, e};
              n++;
            end
          end
          if (n > longest_scan) longest_scan = n;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic apply_request(input req_row_t r);
    res_t due[$];
    res_t t;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= r.op;
    req_ch.object_pointer <= r.ptr;
    req_ch.slot_index <= r.idx;
    req_ch.ref_kind <= r.kind;
    do @(posedge clk); while (!req_ch.ready);
    predict_slot_results(r, due);
    if (r.typed) begin
      t.slot = r.t_slot;
      t.ptr = r.t_ptr;
      t.kind = r.kind;
      t.status = r.t_status;
      t.last = 1'b1;
      due = {t};
    end
    foreach (due[i]) pending_results = {pending_results, due[i]};
    if (r.op != OP_IGNORED) requests_done++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic req_row_t mk_row(input logic [1:0] op, input logic [31:0] ptr,
                                      input logic [5:0] idx, input logic [1:0] kind,
                                      input logic typed, input logic [5:0] t_slot,
                                      input logic [31:0] t_ptr, input status_t t_status);
    req_row_t r;
    r.op = op;
    r.ptr = ptr;
    r.idx = idx;
    r.kind = kind;
    r.typed = typed;
    r.t_slot = t_slot;
    r.t_ptr = t_ptr;
    r.t_status = t_status;
    return r;
  endfunction

  function automatic req_row_t random_request();
    req_row_t r;
    int       pick;
    int       busy[$];
    r = '0;
    pick = $urandom_range(99);
    r.kind = 2'($urandom_range(3));
    r.idx = 6'($urandom_range(63));
    case ($urandom_range(7))
      0: r.ptr = '0;
      1: r.ptr = '1;
      default: r.ptr = $urandom;
    endcase
    if (filling) begin
      if (free_slots == '0) r.op = (pick < 35) ? OP_SCAN : OP_ADD;
      else if (pick < 88) r.op = OP_ADD;
      else if (pick < 95) r.op = OP_REMOVE;
      else if (pick < 98) r.op = OP_SCAN;
      else r.op = OP_IGNORED;
    end else begin
      if (pick < 8) r.op = OP_ADD;
      else if (pick < 84) r.op = OP_REMOVE;
      else if (pick < 97) r.op = OP_SCAN;
      else r.op = OP_IGNORED;
    end
    if (r.op == OP_REMOVE && $urandom_range(99) < 85) begin
      for (int i = 0; i < 64; i++) if (!free_slots[i]) busy = {busy, i};
      if (busy.size() != 0) r.idx = 6'(busy[$urandom_range(busy.size() - 1)]);
    end
    return r;
  endfunction

  initial begin
    req_row_t plan[$];
    req_row_t r;
    int       done;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.object_pointer = '0;
    req_ch.slot_index = '0;
    req_ch.ref_kind = '0;
    rsp_ch.ready = 1'b0;
    free_slots = '1;
    foreach (held_ptr[i]) held_ptr[i] = '0;
    error_count = 0;
    cycle_count = 0;
    requests_done = 0;
    results_seen = 0;
    longest_scan = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    src_idle_pct = 35;
    rx_stall_pct = 77;
    filling = 1'b1;
    full_hits = 0;

    plan = {plan, mk_row(OP_SCAN,    '0,           6'd0,  2'd2, 1'b1, 6'd0,  '0,
                         STAT_NONE_BUSY)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd0,  2'd0, 1'b1, 6'd0,  '0,
                         STAT_NOT_BUSY)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd63, 2'd3, 1'b1, 6'd63, '0,
                         STAT_NOT_BUSY)};
    plan = {plan, mk_row(OP_ADD,     32'hFFFFFFFF, 6'd0,  2'd3, 1'b1, 6'd0,  32'hFFFFFFFF,
                         STAT_OK)};
    plan = {plan, mk_row(OP_ADD,     '0,           6'd63, 2'd0, 1'b1, 6'd1,  '0, STAT_OK)};
    plan = {plan, mk_row(OP_ADD,     32'hA5A5A5A5, 6'd0,  2'd1, 1'b1, 6'd2,  32'hA5A5A5A5,
                         STAT_OK)};
    plan = {plan, mk_row(OP_IGNORED, 32'hFFFFFFFF, 6'd63, 2'd3, 1'b0, '0, '0, STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd1,  2'd2, 1'b1, 6'd1,  '0, STAT_OK)};
    plan = {plan, mk_row(OP_ADD,     32'h5A5A5A5A, 6'd0,  2'd2, 1'b1, 6'd1,  32'h5A5A5A5A,
                         STAT_OK)};
    plan = {plan, mk_row(OP_SCAN,    '0,           6'd0,  2'd1, 1'b0, '0, '0, STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd2,  2'd0, 1'b1, 6'd2,  32'hA5A5A5A5,
                         STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd2,  2'd1, 1'b1, 6'd2,  '0,
                         STAT_NOT_BUSY)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd42, 2'd2, 1'b1, 6'd42, '0,
                         STAT_NOT_BUSY)};
    plan = {plan, mk_row(OP_ADD,     32'h12345678, 6'd0,  2'd1, 1'b1, 6'd2,  32'h12345678,
                         STAT_OK)};
    plan = {plan, mk_row(OP_SCAN,    '0,           6'd0,  2'd3, 1'b0, '0, '0, STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd0,  2'd3, 1'b1, 6'd0,  32'hFFFFFFFF,
                         STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd1,  2'd0, 1'b1, 6'd1,  32'h5A5A5A5A,
                         STAT_OK)};
    plan = {plan, mk_row(OP_REMOVE,  '0,           6'd2,  2'd1, 1'b1, 6'd2,  32'h12345678,
                         STAT_OK)};
    plan = {plan, mk_row(OP_SCAN,    '0,           6'd0,  2'd0, 1'b1, 6'd0,  '0,
                         STAT_NONE_BUSY)};
    plan = {plan, mk_row(OP_IGNORED, '0,           6'd0,  2'd0, 1'b0, '0, '0, STAT_OK)};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) apply_request(plan[i]);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 77 : 0;
      rx_stall_pct = (ph == 0) ? 77 : (ph == 1) ? 35 : 0;
      done = requests_done;
      while (requests_done - done < RANDOM_PER_PHASE) begin
        if ($urandom_range(99) == 0) wait_drained();
        r = random_request();
        apply_request(r);
        if (filling && free_slots == '0) begin
          full_hits++;
          if (full_hits >= 5) filling = 1'b0;
        end else if (!filling && &free_slots) begin
          filling = 1'b1;
          full_hits = 0;
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("%0d requests, %0d results; longest scan %0d slots", requests_done,
             results_seen, longest_scan);
    $display("status counts: ok %0d, full %0d, not busy %0d, nothing busy %0d",
             status_tally[STAT_OK], status_tally[STAT_FULL],
             status_tally[STAT_NOT_BUSY], status_tally[STAT_NONE_BUSY]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
